/* sv/rpfa_pkg.sv */
// Shared types, codes and widths of the refcounted page-frame allocator.
package rpfa_pkg;

	// Fixed field widths of the request and response items
	localparam int MODE_W   = 3;
	localparam int PAGE_W   = 14;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 8;
	localparam int FREE_W   = 15;

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_KERNEL_END = 1'b0;

	// Default sizing
	localparam int NUM_PAGES_DEF = 16384;
	localparam int REF_BITS_DEF  = 8;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FREE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INCR   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DECR   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DONATE = 3'd5;

	// Response status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_SAT   = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} rpfa_state_t;

endpackage

/* sv/rpfa_ifs.sv */
// Valid/ready channel interfaces for allocator requests and responses.
interface rpfa_req_if;
	logic                          valid;
	logic                          ready;
	logic [rpfa_pkg::MODE_W-1:0]   mode;
	logic [rpfa_pkg::PAGE_W-1:0]   page_num;

	modport source (output valid, output mode, output page_num, input ready);
	modport sink   (input valid, input mode, input page_num, output ready);
endinterface

interface rpfa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rpfa_pkg::STATUS_W-1:0] status;
	logic [rpfa_pkg::PAGE_W-1:0]   page_out;
	logic [rpfa_pkg::CNT_W-1:0]    ref_count;
	logic [rpfa_pkg::FREE_W-1:0]   free_count;

	modport source (output valid, output status, output page_out, output ref_count,
		output free_count, input ready);
	modport sink   (input valid, input status, input page_out, input ref_count,
		input free_count, output ready);
endinterface

/* sv/refcounted_page_frame_allocator.sv */
// Refcounted page-frame allocator: LIFO free stack plus per-page reference counts.
// On each request item the accept edge reads the reference table and the top of the
// free stack (synchronous memories with a registered read); the EXEC state then does
// the modify/write-back into both memories and loads the response register. A new
// item is taken while the previous response still waits; its write-back then holds
// until the response register is free. After reset the reference table is swept to
// zero, one entry per cycle, so the request side is held off for the whole sweep;
// configuration writes are taken during that sweep. The free stack itself is never
// cleared: only entries below the free count are ever popped. Counts saturate at 0
// and 2^REF_BITS-1 (status "saturated"), a push onto a full stack is dropped with
// the same status, and a double free pushes the page twice. kernel_end_page sits at
// byte address 0 of the APB port; free and donate reject pages below it.
module refcounted_page_frame_allocator #(
	parameter int NUM_PAGES = rpfa_pkg::NUM_PAGES_DEF,
	parameter int REF_BITS  = rpfa_pkg::REF_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rpfa_req_if.sink                          req,
	rpfa_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rpfa_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rpfa_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rpfa_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int AW = $clog2(NUM_PAGES);       // memory address width
	localparam int CW = $clog2(NUM_PAGES + 1);   // free count width
	localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
	localparam logic [AW-1:0] CLR_LAST = AW'(NUM_PAGES - 1);

	// ---------------- configuration ----------------
	logic [rpfa_pkg::PAGE_W-1:0] kend_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == rpfa_pkg::REG_KERNEL_END);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q <= '0;
		end else if (cfg_wr) begin
			kend_q <= pwdata[rpfa_pkg::PAGE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == rpfa_pkg::REG_KERNEL_END) begin
			prdata = rpfa_pkg::APB_DATA_W'(kend_q);
		end
	end

	// ---------------- control ----------------
	rpfa_pkg::rpfa_state_t state_q, state_d;
	logic [AW-1:0]         clr_q;
	logic                  clr_active;
	logic                  exec_en;
	logic                  req_acc;
	logic                  rsp_valid_q;

	assign req_acc = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpfa_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = rpfa_pkg::ST_IDLE;
			end
			rpfa_pkg::ST_IDLE: begin
				if (req_acc) state_d = rpfa_pkg::ST_EXEC;
			end
			rpfa_pkg::ST_EXEC: begin
				// wait for the response register to be free
				if (!rsp_valid_q || rsp.ready) state_d = rpfa_pkg::ST_IDLE;
			end
			default: begin
				state_d = rpfa_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		clr_active = 1'b0;
		exec_en    = 1'b0;
		req.ready  = 1'b0;
		case (state_q)
			rpfa_pkg::ST_CLEAR: begin
				clr_active = 1'b1;
			end
			rpfa_pkg::ST_IDLE: begin
				req.ready = 1'b1;
			end
			rpfa_pkg::ST_EXEC: begin
				// response slot must be empty or draining this cycle
				exec_en = !rsp_valid_q || rsp.ready;
			end
			default: begin
				clr_active = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpfa_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_active) clr_q <= clr_q + AW'(1);
		end
	end

	// ---------------- stage 1: request capture + memory read ----------------
	logic [rpfa_pkg::MODE_W-1:0] mode_s1;
	logic [rpfa_pkg::PAGE_W-1:0] pg_s1;
	logic [REF_BITS-1:0]         ref_rd_s1;
	logic [rpfa_pkg::PAGE_W-1:0] stk_rd_s1;
	logic [CW-1:0]               free_q, free_d;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_s1 <= req.mode;
			pg_s1   <= req.page_num;
		end
	end

	// reference table: one write port, one registered read port
	logic [REF_BITS-1:0] ref_mem [NUM_PAGES];
	logic                ref_we;
	logic [AW-1:0]       ref_waddr;
	logic [REF_BITS-1:0] ref_wdata;
	logic                exec_ref_we;
	logic [AW-1:0]       exec_ref_addr;
	logic [REF_BITS-1:0] exec_ref_data;

	assign ref_we    = clr_active || exec_ref_we;
	assign ref_waddr = clr_active ? clr_q : exec_ref_addr;
	assign ref_wdata = clr_active ? '0 : exec_ref_data;

	always_ff @(posedge clk) begin
		if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
		if (req_acc) ref_rd_s1 <= ref_mem[AW'(req.page_num)];
	end

	// free stack: push at free_q, pop reads free_q-1
	logic [rpfa_pkg::PAGE_W-1:0] stk_mem [NUM_PAGES];
	logic                        stk_we;

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[AW'(free_q)] <= pg_s1;
		if (req_acc) stk_rd_s1 <= stk_mem[AW'(free_q - CW'(1))];
	end

	// ---------------- stage 2: modify / write-back ----------------
	logic [rpfa_pkg::STATUS_W-1:0] status_d;
	logic [rpfa_pkg::PAGE_W-1:0]   page_d;
	logic [REF_BITS-1:0]           cnt_d;
	logic                          in_range;
	logic                          push_req;

	always_comb begin
		logic [REF_BITS-1:0] v;
		v             = '0;
		status_d      = rpfa_pkg::STAT_OK;
		page_d        = pg_s1;
		cnt_d         = '0;
		free_d        = free_q;
		exec_ref_we   = 1'b0;
		exec_ref_addr = AW'(pg_s1);
		exec_ref_data = '0;
		push_req      = 1'b0;
		in_range      = 32'(pg_s1) < 32'(NUM_PAGES);

		if (mode_s1 == rpfa_pkg::MODE_ALLOC) begin
			if (free_q == '0) begin
				status_d = rpfa_pkg::STAT_EMPTY;
				page_d   = '0;
			end else begin
				free_d        = free_q - CW'(1);
				page_d        = stk_rd_s1;
				exec_ref_we   = 1'b1;
				exec_ref_addr = AW'(stk_rd_s1);
				exec_ref_data = REF_BITS'(1);
				cnt_d         = REF_BITS'(1);
			end
		end else if (!in_range) begin
			status_d = rpfa_pkg::STAT_RANGE;
		end else if (mode_s1 == rpfa_pkg::MODE_FREE || mode_s1 == rpfa_pkg::MODE_DONATE) begin
			if (pg_s1 < kend_q) begin
				status_d = rpfa_pkg::STAT_RANGE;
			end else begin
				// donate drops the count first, then frees
				v = (mode_s1 == rpfa_pkg::MODE_DONATE) ? '0 : ref_rd_s1;
				if (v != '0) v = v - REF_BITS'(1);
				exec_ref_we   = 1'b1;
				exec_ref_data = v;
				cnt_d         = v;
				if (v == '0) begin
					if (free_q >= CW'(NUM_PAGES)) begin
						status_d = rpfa_pkg::STAT_SAT;
					end else begin
						push_req = 1'b1;
						free_d   = free_q + CW'(1);
					end
				end
			end
		end else if (mode_s1 == rpfa_pkg::MODE_INCR) begin
			if (ref_rd_s1 == REF_MAX) begin
				status_d = rpfa_pkg::STAT_SAT;
				cnt_d    = ref_rd_s1;
			end else begin
				exec_ref_we   = 1'b1;
				exec_ref_data = ref_rd_s1 + REF_BITS'(1);
				cnt_d         = ref_rd_s1 + REF_BITS'(1);
			end
		end else if (mode_s1 == rpfa_pkg::MODE_DECR) begin
			if (ref_rd_s1 == '0) begin
				status_d = rpfa_pkg::STAT_SAT;
			end else begin
				exec_ref_we   = 1'b1;
				exec_ref_data = ref_rd_s1 - REF_BITS'(1);
				cnt_d         = ref_rd_s1 - REF_BITS'(1);
			end
		end else begin
			// query, and the unused codes behave as query
			cnt_d = ref_rd_s1;
		end

		exec_ref_we = exec_ref_we && exec_en;
	end

	assign stk_we = push_req && exec_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_en) begin
				free_q      <= free_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	logic [rpfa_pkg::STATUS_W-1:0] status_q;
	logic [rpfa_pkg::PAGE_W-1:0]   page_q;
	logic [rpfa_pkg::CNT_W-1:0]    cnt_q;
	logic [rpfa_pkg::FREE_W-1:0]   fcnt_q;

	always_ff @(posedge clk) begin
		if (exec_en) begin
			status_q <= status_d;
			page_q   <= page_d;
			cnt_q    <= rpfa_pkg::CNT_W'(cnt_d);
			fcnt_q   <= rpfa_pkg::FREE_W'(free_d);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.page_out   = page_q;
	assign rsp.ref_count  = cnt_q;
	assign rsp.free_count = fcnt_q;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the refcounted page-frame allocator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpfa_pkg::*;

	localparam int PAGES       = NUM_PAGES_DEF;
	localparam int CNT_MAX     = (1 << REF_BITS_DEF) - 1;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 56;
	localparam int CALM_ITEMS  = 12;

	// Modes 6 and 7 have no function of their own; the block treats them as a query.
	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

	// kernel_end_page is register 0, so it sits at byte address 0.
	localparam logic [APB_ADDR_W-1:0] KEND_ADDR = APB_ADDR_W'(4 * int'(REG_KERNEL_END));

	// Idle profiles per random phase: none, sender gaps, receiver stalls, both.
	localparam int GAP_PCT [4]   = '{0, 49, 0, 8};
	localparam int STALL_PCT [4] = '{0, 0, 49, 8};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   page;
		logic [CNT_W-1:0]    cnt;
		logic [FREE_W-1:0]   free;
	} alloc_rsp_t;

	// One row of the directed plan: either a kernel_end_page write or a request.
	// Where typed is set, rsp is the response read straight off the spec.
	typedef struct {
		bit                set_kend;
		logic [MODE_W-1:0] mode;
		logic [PAGE_W-1:0] page;
		bit                typed;
		alloc_rsp_t        rsp;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	rpfa_req_if req_ch();
	rpfa_rsp_if rsp_ch();

	refcounted_page_frame_allocator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the allocator: counts, LIFO of free pages, depth and the kernel boundary.
	logic [CNT_W-1:0]  ref_cnt [PAGES];
	logic [PAGE_W-1:0] free_stack [PAGES];
	int                free_depth = 0;
	logic [PAGE_W-1:0] kernel_end = '0;

	alloc_rsp_t        awaited_rsp [$];
	int                fail_cnt = 0;
	int                cycle_cnt = 0;
	int                gap_pct = 0;
	int                stall_pct = 0;
	int                pool_base = 0;
	logic [PAGE_W-1:0] last_alloc = '0;

	// Directed plan, starting from the empty stack after reset with kernel_end_page 0.
	plan_row_t dir_plan [24] = '{
		// alloc on an empty stack
		'{0, MODE_ALLOC,  14'd0,     1, '{STAT_EMPTY, 14'd0,     8'd0, 15'd0}},
		'{0, MODE_QUERY,  14'd0,     1, '{STAT_OK,    14'd0,     8'd0, 15'd0}},
		'{0, MODE_QUERY,  14'd16383, 1, '{STAT_OK,    14'd16383, 8'd0, 15'd0}},
		// decr at zero saturates
		'{0, MODE_DECR,   14'd5,     1, '{STAT_SAT,   14'd5,     8'd0, 15'd0}},
		'{0, MODE_INCR,   14'd5,     1, '{STAT_OK,    14'd5,     8'd1, 15'd0}},
		'{0, MODE_FREE,   14'd5,     1, '{STAT_OK,    14'd5,     8'd0, 15'd1}},
		// double free leaves a second copy on the stack
		'{0, MODE_FREE,   14'd5,     1, '{STAT_OK,    14'd5,     8'd0, 15'd2}},
		'{0, MODE_DONATE, 14'd16383, 1, '{STAT_OK,    14'd16383, 8'd0, 15'd3}},
		'{0, MODE_DONATE, 14'd0,     1, '{STAT_OK,    14'd0,     8'd0, 15'd4}},
		// pops come back in LIFO order; page_num is a don't-care for alloc
		'{0, MODE_ALLOC,  14'd16383, 1, '{STAT_OK,    14'd0,     8'd1, 15'd3}},
		'{0, MODE_ALLOC,  14'd0,     1, '{STAT_OK,    14'd16383, 8'd1, 15'd2}},
		'{0, MODE_ALLOC,  14'd0,     1, '{STAT_OK,    14'd5,     8'd1, 15'd1}},
		'{0, MODE_ALLOC,  14'd0,     1, '{STAT_OK,    14'd5,     8'd1, 15'd0}},
		'{0, MODE_INCR,   14'd5,     0, '0},
		'{0, MODE_FREE,   14'd5,     0, '0},
		'{0, MODE_SPARE6, 14'h2AAA,  0, '0},
		'{0, MODE_SPARE7, 14'h1555,  0, '0},
		'{0, MODE_DECR,   14'd5,     0, '0},
		// top boundary: only the last page may be freed
		'{1, MODE_QUERY,  14'd16383, 0, '0},
		'{0, MODE_FREE,   14'd100,   1, '{STAT_RANGE, 14'd100,   8'd0, 15'd0}},
		'{0, MODE_DONATE, 14'd16382, 1, '{STAT_RANGE, 14'd16382, 8'd0, 15'd0}},
		'{0, MODE_FREE,   14'd16383, 0, '0},
		// incr ignores the boundary
		'{0, MODE_INCR,   14'd0,     0, '0},
		'{0, MODE_ALLOC,  14'd0,     0, '0}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Receiver back-pressure, redrawn each cycle.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Predicts one request against the shadow state and returns its response.
	function automatic alloc_rsp_t apply_request(logic [MODE_W-1:0] mode,
			logic [PAGE_W-1:0] pg);
		alloc_rsp_t r;
		r = '{STAT_OK, pg, '0, '0};
		case (mode)
			MODE_ALLOC: begin
				if (free_depth == 0) begin
					r.status = STAT_EMPTY;
					r.page   = '0;
				end else begin
					free_depth--;
					r.page = free_stack[free_depth];
					ref_cnt[r.page] = CNT_W'(1);
					r.cnt = CNT_W'(1);
				end
			end
			MODE_FREE, MODE_DONATE: begin
				if (pg < kernel_end) begin
					r.status = STAT_RANGE;
				end else begin
					if (mode == MODE_DONATE)
						ref_cnt[pg] = '0;
					if (ref_cnt[pg] != 0)
						ref_cnt[pg] = ref_cnt[pg] - 1'b1;
					// count at zero: push, or refuse when the stack is full (count stays 0)
					if (ref_cnt[pg] == 0) begin
						if (free_depth >= PAGES) begin
							r.status = STAT_SAT;
						end else begin
							free_stack[free_depth] = pg;
							free_depth++;
						end
					end
					r.cnt = ref_cnt[pg];
				end
			end
			MODE_INCR: begin
				if (ref_cnt[pg] == CNT_MAX)
					r.status = STAT_SAT;
				else
					ref_cnt[pg] = ref_cnt[pg] + 1'b1;
				r.cnt = ref_cnt[pg];
			end
			MODE_DECR: begin
				if (ref_cnt[pg] == 0)
					r.status = STAT_SAT;
				else
					ref_cnt[pg] = ref_cnt[pg] - 1'b1;
				r.cnt = ref_cnt[pg];
			end
			default: r.cnt = ref_cnt[pg];
		endcase
		r.free = FREE_W'(free_depth);
		return r;
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_cnt++;
		end
	endfunction

	// Response checker: every accepted response is matched against the oldest prediction.
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (awaited_rsp.size() == 0) begin
				$error("response with no request outstanding");
				fail_cnt++;
			end else begin
				want = awaited_rsp.pop_front();
				check_field("status",     32'(want.status), 32'(rsp_ch.status));
				check_field("page_out",   32'(want.page),   32'(rsp_ch.page_out));
				check_field("ref_count",  32'(want.cnt),    32'(rsp_ch.ref_count));
				check_field("free_count", 32'(want.free),   32'(rsp_ch.free_count));
			end
		end
	end

	// Mostly alloc/free/donate traffic, with count updates and the odd spare mode.
	function automatic logic [MODE_W-1:0] pick_mode();
		int sel;
		sel = $urandom_range(99);
		if (sel < 18) return MODE_ALLOC;
		if (sel < 38) return MODE_FREE;
		if (sel < 53) return MODE_INCR;
		if (sel < 68) return MODE_DECR;
		if (sel < 78) return MODE_QUERY;
		if (sel < 95) return MODE_DONATE;
		return $urandom_range(1) ? MODE_SPARE7 : MODE_SPARE6;
	endfunction

	// Pages mostly from a small pool above the boundary so counts and stack entries repeat.
	function automatic logic [PAGE_W-1:0] pick_page();
		int sel;
		int pg;
		sel = $urandom_range(99);
		if (sel < 15) return last_alloc;
		if (sel < 25) return PAGE_W'($urandom);
		if (sel < 33 && kernel_end != 0) return PAGE_W'($urandom_range(int'(kernel_end) - 1));
		if (sel < 38) return $urandom_range(1) ? '1 : '0;
		pg = pool_base + $urandom_range(15);
		return (pg > PAGES - 1) ? PAGE_W'(PAGES - 1) : PAGE_W'(pg);
	endfunction

	// Sends one request item; entered and left at a falling edge.
	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] pg,
			input bit typed = 1'b0, input alloc_rsp_t typed_rsp = '0);
		alloc_rsp_t r;
		while ($urandom_range(99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= mode;
		req_ch.page_num <= pg;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		// prediction in acceptance order keeps the shadow in step with the block
		r = apply_request(mode, pg);
		if (mode == MODE_ALLOC && r.status == STAT_OK)
			last_alloc = r.page;
		awaited_rsp.push_back(typed ? typed_rsp : r);
		@(negedge clk);
	endtask

	// Drops valid and waits until every response is back, plus a short settle.
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (awaited_rsp.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// One APB transfer, setup then access, with the bus left idle after it.
	task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
			output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= KEND_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_kernel_end(input logic [PAGE_W-1:0] value);
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b1, APB_DATA_W'(value), rd);
		kernel_end = value;
		apb_access(1'b0, '0, rd);
		check_field("kernel_end_page", APB_DATA_W'(value), rd);
	endtask

	// Drives one count to its ceiling and past it, then decrements it once.
	task automatic saturate_count();
		logic [PAGE_W-1:0] sat_pg;
		sat_pg = PAGE_W'($urandom_range(PAGES - 1));
		repeat (CNT_MAX + 1) send_request(MODE_INCR, sat_pg);
		send_request(MODE_DECR, sat_pg);
	endtask

	initial begin
		logic [PAGE_W-1:0] kend_val;
		int span;
		foreach (ref_cnt[i])
			ref_cnt[i] = '0;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = MODE_QUERY;
		req_ch.page_num   = '0;
		rsp_ch.ready      = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = KEND_ADDR;
		pwdata            = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// The block sweeps its count table after reset; the register port is live
		// meanwhile, and requests simply wait for ready.
		program_kernel_end('0);

		foreach (dir_plan[i]) begin
			if (dir_plan[i].set_kend) begin
				quiesce();
				program_kernel_end(dir_plan[i].page);
			end else begin
				send_request(dir_plan[i].mode, dir_plan[i].page, dir_plan[i].typed,
					dir_plan[i].rsp);
			end
		end

		// Random phases, each with its own boundary and idle profile. Each opens with a
		// calm stretch before the gaps and stalls start. The last follows a count that
		// was driven to its ceiling.
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4)
				saturate_count();
			quiesce();
			gap_pct   = 0;
			stall_pct = 0;
			case (ph)
				0:       kend_val = '0;
				1:       kend_val = PAGE_W'($urandom_range(2000));
				2:       kend_val = PAGE_W'($urandom_range(PAGES - 1));
				3:       kend_val = PAGE_W'(PAGES - 1);
				default: kend_val = PAGE_W'($urandom_range(8000));
			endcase
			program_kernel_end(kend_val);
			span = PAGES - 1 - int'(kernel_end) - 15;
			pool_base = int'(kernel_end) + ((span > 0) ? int'($urandom_range(span)) : 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == CALM_ITEMS) begin
					gap_pct   = GAP_PCT[ph % 4];
					stall_pct = STALL_PCT[ph % 4];
				end
				send_request(pick_mode(), pick_page());
			end
		end

		quiesce();
		if (fail_cnt == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
